// ----- rtl/core/midi_cc_learn_mapper_assert.svh -----
// Assertion macros for the controller learn mapper checker.
`ifndef MIDI_CC_LEARN_MAPPER_ASSERT_SVH
`define MIDI_CC_LEARN_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcl assertion failed");

// Next-cycle implication, disabled during reset.
`define MCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcl assertion failed");

`endif

// ----- rtl/core/mcl_pkg.sv -----
// Shared types, codes and constants of the controller learn mapper.
`timescale 1ns / 1ps

package mcl_pkg;

  localparam int DEF_NUM_SLOTS = 10;
  localparam int DEF_NUM_STEMS = 6;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 4;
  localparam int CC_W   = 7;
  localparam int CH_W   = 6;
  localparam int VAL_W  = 7;
  localparam int MCC_W  = 8;
  localparam int KIND_W = 2;

  localparam logic [OP_W-1:0] OP_MSG       = 3'd0;
  localparam logic [OP_W-1:0] OP_LEARN_ON  = 3'd1;
  localparam logic [OP_W-1:0] OP_LEARN_OFF = 3'd2;
  localparam logic [OP_W-1:0] OP_SET       = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

  localparam logic [KIND_W-1:0] KIND_VOLUME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEARNED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd3;

  localparam logic signed [MCC_W-1:0] UNMAPPED_CC = -8'sd1;
  localparam logic signed [CH_W-1:0]  ANY_CH      = -6'sd1;
  localparam logic [VAL_W-1:0]        TRIG_LEVEL  = 7'd64;

  typedef enum logic [1:0] {
    CMD_MSG,
    CMD_SET,
    CMD_REMOVE,
    CMD_QUERY
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Command packet that walks down the row of slot cells.
  typedef struct packed {
    logic                     vld;
    cmd_t                     cmd;
    logic                     learned;
    logic [SLOT_W-1:0]        slot;
    logic [CC_W-1:0]          cc;
    logic signed [CH_W-1:0]   ch;
    logic [VAL_W-1:0]         val;
    logic signed [MCC_W-1:0]  qcc;
  } pkt_t;

  // Match report of one cell.
  typedef struct packed {
    logic              vld;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] target;
    logic [VAL_W-1:0]  level;
  } hit_t;

endpackage

// ----- rtl/core/mcl_cell.sv -----
// One slot cell: holds a mapping, acts on the passing packet, hands it on.
`timescale 1ns / 1ps

module mcl_cell import mcl_pkg::*; #(
  parameter int   IDX     = 0,
  parameter logic IS_STEM = 1'b1
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  pkt_t pkt_in,
  output pkt_t pkt_out,
  output hit_t hit
);

  logic signed [MCC_W-1:0] entry_cc;
  logic signed [CH_W-1:0]  entry_ch;
  logic                    sel;
  logic                    cc_eq;
  logic                    ch_ok;
  logic                    fire;
  pkt_t                    pkt_fwd;

  assign sel   = (pkt_in.slot == SLOT_W'(IDX));
  assign cc_eq = (entry_cc == {1'b0, pkt_in.cc});
  assign ch_ok = (entry_ch == ANY_CH) || (entry_ch == pkt_in.ch);
  assign fire  = pkt_in.vld && (pkt_in.cmd == CMD_MSG) && cc_eq && ch_ok &&
                 (IS_STEM || (pkt_in.val >= TRIG_LEVEL));

  always_comb begin
    hit.vld    = fire;
    hit.kind   = IS_STEM ? KIND_VOLUME : KIND_TRIGGER;
    hit.target = SLOT_W'(IDX);
    hit.level  = IS_STEM ? pkt_in.val : '0;
  end

  // Pass the packet on; a query for this slot picks up the stored number.
  always_comb begin
    pkt_fwd = pkt_in;
    if (pkt_in.cmd == CMD_QUERY && sel) begin
      pkt_fwd.qcc = entry_cc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_cc <= UNMAPPED_CC;
      entry_ch <= ANY_CH;
    end else if (adv && pkt_in.vld) begin
      case (pkt_in.cmd)
        CMD_SET: begin
          if (sel) begin
            entry_cc <= {1'b0, pkt_in.cc};
            entry_ch <= pkt_in.ch;
          end else if (cc_eq) begin
            entry_cc <= UNMAPPED_CC;
            entry_ch <= ANY_CH;
          end
        end
        CMD_REMOVE: begin
          if (sel) begin
            entry_cc <= UNMAPPED_CC;
            entry_ch <= ANY_CH;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.vld <= 1'b0;
    end else if (adv) begin
      pkt_out <= pkt_fwd;
    end
  end

endmodule

// ----- rtl/core/mcl_ctrl.sv -----
// Sequencer: launches packets, gathers cell hits, drives the result register.
`timescale 1ns / 1ps

module mcl_ctrl import mcl_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [CC_W-1:0]          cc_number,
  input  logic signed [CH_W-1:0]   channel,
  input  logic [VAL_W-1:0]         cc_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        kind,
  output logic [SLOT_W-1:0]        target,
  output logic [VAL_W-1:0]         level,
  output logic signed [MCC_W-1:0]  mapped_cc,
  output logic                     last,
  output logic                     adv,
  output pkt_t                     pkt_head,
  input  pkt_t                     pkt_end,
  input  hit_t                     hits [NUM_SLOTS]
);

  state_t            state;
  state_t            state_next;
  logic              armed;
  logic [SLOT_W-1:0] learn_slot;
  hit_t              pend;
  hit_t              hit_any;
  pkt_t              launch;
  logic              launch_need;
  logic              accept;
  logic              slot_ok;
  logic              done;
  logic              final_v;
  logic [KIND_W-1:0] final_kind;
  logic [MCC_W-1:0]  final_mcc;
  logic              out_free;
  logic              push_mid;
  logic              push_end;

  assign accept  = in_valid && in_ready;
  assign slot_ok = ({1'b0, slot} < (SLOT_W+1)'(NUM_SLOTS));
  assign done    = pkt_end.vld;

  always_comb begin
    launch         = '0;
    launch.vld     = 1'b1;
    launch.cmd     = CMD_MSG;
    launch.slot    = slot;
    launch.cc      = cc_number;
    launch.ch      = channel;
    launch.val     = cc_value;
    launch.qcc     = UNMAPPED_CC;
    launch_need    = 1'b0;
    case (op)
      OP_MSG: begin
        launch_need = 1'b1;
        if (armed) begin
          launch.cmd     = CMD_SET;
          launch.learned = 1'b1;
          launch.slot    = learn_slot;
        end
      end
      OP_SET: begin
        launch.cmd  = CMD_SET;
        launch_need = slot_ok;
      end
      OP_REMOVE: begin
        launch.cmd  = CMD_REMOVE;
        launch_need = 1'b1;
      end
      OP_QUERY: begin
        launch.cmd  = CMD_QUERY;
        launch_need = 1'b1;
      end
      default: launch_need = 1'b0;
    endcase
  end

  // Only the firing cell contributes; idle cells still show their constants.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hits[i].vld) begin
        hit_any = hit_any | hits[i];
      end
    end
  end

  always_comb begin
    final_v    = 1'b0;
    final_kind = KIND_QUERY;
    final_mcc  = pkt_end.qcc;
    if (pend.vld) begin
      final_v = 1'b1;
    end else if (pkt_end.learned) begin
      final_v    = 1'b1;
      final_kind = KIND_LEARNED;
      final_mcc  = {1'b0, pkt_end.cc};
    end else if (pkt_end.cmd == CMD_QUERY) begin
      final_v = 1'b1;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign adv      = out_free || !((hit_any.vld && pend.vld) || (done && final_v));
  assign push_mid = out_free && hit_any.vld && pend.vld;
  assign push_end = out_free && done && final_v;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && launch_need) state_next = ST_RUN;
      ST_RUN:  if (done && adv) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      learn_slot <= '0;
    end else if (accept) begin
      case (op)
        OP_LEARN_ON: begin
          if (slot_ok) begin
            armed      <= 1'b1;
            learn_slot <= slot;
          end
        end
        OP_LEARN_OFF: armed <= 1'b0;
        OP_MSG:       armed <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_head.vld <= 1'b0;
    end else if (accept && launch_need) begin
      pkt_head <= launch;
    end else if (adv) begin
      pkt_head.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.vld <= 1'b0;
    end else if (adv) begin
      if (hit_any.vld) begin
        pend <= hit_any;
      end else if (done) begin
        pend.vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid) begin
      out_valid <= 1'b1;
      kind      <= pend.kind;
      target    <= pend.target;
      level     <= pend.level;
      mapped_cc <= '0;
      last      <= 1'b0;
    end else if (push_end) begin
      out_valid <= 1'b1;
      last      <= 1'b1;
      if (pend.vld) begin
        kind      <= pend.kind;
        target    <= pend.target;
        level     <= pend.level;
        mapped_cc <= '0;
      end else begin
        kind      <= final_kind;
        target    <= pkt_end.slot;
        level     <= '0;
        mapped_cc <= final_mcc;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/midi_cc_learn_mapper.sv -----
// Top level of the controller learn mapper: sequencer plus a row of slot cells.
`timescale 1ns / 1ps

// Maps MIDI controller messages to stem volume and transport actions through a
// table of NUM_SLOTS slots, one slot per cell in a row of cells. Each accepted
// item becomes a command packet that walks the row one cell per cycle while the
// output side does not stall; every cell applies set, remove, learn capture or
// query to its own mapping as the packet passes and reports a match for
// controller messages. Results leave in slot order through a registered output;
// the last result of an item carries last = 1. A controller message, set,
// remove or query holds in_ready low until its packet has walked the whole
// cell row and come back. Start learn, stop learn, out-of-range set and
// unknown ops are absorbed in the accept cycle, so the next item can transfer
// in the cycle after. While learning is armed, the next controller message is
// captured into the learn slot and answered by a single learned result. All
// mappings reset to unmapped on any channel.
module midi_cc_learn_mapper import mcl_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  parameter int NUM_STEMS = DEF_NUM_STEMS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [CC_W-1:0]          cc_number,
  input  logic signed [CH_W-1:0]   channel,
  input  logic [VAL_W-1:0]         cc_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        kind,
  output logic [SLOT_W-1:0]        target,
  output logic [VAL_W-1:0]         level,
  output logic signed [MCC_W-1:0]  mapped_cc,
  output logic                     last
);

  // Packet taps between cells: pkt[0] leaves the sequencer, pkt[NUM_SLOTS]
  // returns to it and marks the end of the walk.
  pkt_t pkt [NUM_SLOTS+1];
  hit_t hits [NUM_SLOTS];
  logic adv;

  mcl_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .slot      (slot),
    .cc_number (cc_number),
    .channel   (channel),
    .cc_value  (cc_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .target    (target),
    .level     (level),
    .mapped_cc (mapped_cc),
    .last      (last),
    .adv       (adv),
    .pkt_head  (pkt[0]),
    .pkt_end   (pkt[NUM_SLOTS]),
    .hits      (hits)
  );

  // Build the row; the first NUM_STEMS cells are volume slots, the rest
  // fire transport triggers.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    mcl_cell #(
      .IDX     (i),
      .IS_STEM (i < NUM_STEMS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .pkt_in  (pkt[i]),
      .pkt_out (pkt[i+1]),
      .hit     (hits[i])
    );
  end

endmodule

// ----- rtl/core/mcl_checker.sv -----
// Port-level checker for the controller learn mapper, bound to the top level.
`timescale 1ns / 1ps
`include "midi_cc_learn_mapper_assert.svh"

module mcl_checker import mcl_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [KIND_W-1:0]        kind,
  input logic [SLOT_W-1:0]        target,
  input logic [VAL_W-1:0]         level,
  input logic signed [MCC_W-1:0]  mapped_cc,
  input logic                     last
);

  `MCL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(kind) && $stable(target) && $stable(level) && $stable(last))
  `MCL_ASSERT_IMPL(a_busy_mid_burst, clk, rst, out_valid && !last, !in_ready)
  `MCL_ASSERT_IMPL(a_single_is_last, clk, rst, out_valid && (kind == KIND_LEARNED || kind == KIND_QUERY), last && level == '0)
  `MCL_ASSERT_IMPL(a_action_fields, clk, rst, out_valid && (kind == KIND_VOLUME || kind == KIND_TRIGGER), mapped_cc == '0)

endmodule

bind midi_cc_learn_mapper mcl_checker u_mcl_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the controller learn mapper.
`timescale 1ns / 1ps

module tb;
  import mcl_pkg::*;

  localparam int NSLOT = DEF_NUM_SLOTS;
  localparam int NSTEM = DEF_NUM_STEMS;

  // The two op codes the block has no use for; it must drop them silently.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  // Watchdog limit, with lots of headroom over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 270;
  // Quiet time after the last result: one full walk along the row plus margin.
  localparam int DRAIN_CYCLES = NSLOT + 10;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SLOT_W-1:0]       target;
    logic [VAL_W-1:0]        level;
    logic signed [MCC_W-1:0] mapped_cc;
    logic                    last;
  } mapper_result_t;

  // Shadow of the slot table plus the queue of results it predicts.
  class mapping_scoreboard;
    logic signed [MCC_W-1:0] slot_cc[NSLOT];
    logic signed [CH_W-1:0]  slot_ch[NSLOT];
    bit                      armed;
    logic [SLOT_W-1:0]       armed_slot;
    mapper_result_t          pending_q[$];
    int                      errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        slot_cc[i] = UNMAPPED_CC;
        slot_ch[i] = ANY_CH;
      end
      armed = 1'b0;
      armed_slot = '0;
      errors = 0;
    endfunction

    // Bind a controller number to a slot; the number leaves every other slot.
    function void bind_slot(logic [SLOT_W-1:0] s, logic [CC_W-1:0] cc,
                            logic signed [CH_W-1:0] ch);
      if (s >= NSLOT) return;
      for (int i = 0; i < NSLOT; i++) begin
        if (i != s && int'(slot_cc[i]) == int'(cc)) begin
          slot_cc[i] = UNMAPPED_CC;
          slot_ch[i] = ANY_CH;
        end
      end
      slot_cc[s] = $signed({1'b0, cc});
      slot_ch[s] = ch;
    endfunction

    // Note an accepted input: update the shadow table, queue what it causes.
    function void note_input(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                             logic [CC_W-1:0] cc, logic signed [CH_W-1:0] ch,
                             logic [VAL_W-1:0] val);
      mapper_result_t batch[$];
      mapper_result_t r;
      r = '0;
      case (op)
        OP_MSG: begin
          if (armed) begin
            bind_slot(armed_slot, cc, ch);
            armed = 1'b0;
            r.kind = KIND_LEARNED;
            r.target = armed_slot;
            r.mapped_cc = $signed({1'b0, cc});
            batch.push_back(r);
          end else begin
            for (int i = 0; i < NSLOT; i++) begin
              if (int'(slot_cc[i]) != int'(cc)) continue;
              if (slot_ch[i] != ANY_CH && slot_ch[i] != ch) continue;
              r = '0;
              r.target = i[SLOT_W-1:0];
              if (i < NSTEM) begin
                r.kind = KIND_VOLUME;
                r.level = val;
                batch.push_back(r);
              end else if (val >= TRIG_LEVEL) begin
                r.kind = KIND_TRIGGER;
                batch.push_back(r);
              end
            end
          end
        end
        OP_LEARN_ON: begin
          if (s < NSLOT) begin
            armed = 1'b1;
            armed_slot = s;
          end
        end
        OP_LEARN_OFF: armed = 1'b0;
        OP_SET: bind_slot(s, cc, ch);
        OP_REMOVE: begin
          if (s < NSLOT) begin
            slot_cc[s] = UNMAPPED_CC;
            slot_ch[s] = ANY_CH;
          end
        end
        OP_QUERY: begin
          r.kind = KIND_QUERY;
          r.target = s;
          r.mapped_cc = (s < NSLOT) ? slot_cc[s] : UNMAPPED_CC;
          batch.push_back(r);
        end
        default: ;
      endcase
      for (int k = 0; k < batch.size(); k++) begin
        r = batch[k];
        r.last = (k == batch.size() - 1);
        pending_q.push_back(r);
      end
    endfunction

    function void flag(string what, int exp_v, int act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    // Check one result against the oldest prediction.
    function void check_result(mapper_result_t act);
      mapper_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d target %0d",
                 $time, act.kind, act.target);
        return;
      end
      exp_r = pending_q.pop_front();
      if (act.kind !== exp_r.kind) flag("kind", exp_r.kind, act.kind);
      if (act.target !== exp_r.target) flag("target", exp_r.target, act.target);
      if (act.level !== exp_r.level) flag("level", exp_r.level, act.level);
      if (act.mapped_cc !== exp_r.mapped_cc)
        flag("mapped_cc", int'(exp_r.mapped_cc), int'(act.mapped_cc));
      if (act.last !== exp_r.last) flag("last", exp_r.last, act.last);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         op = OP_QUERY;
  logic [SLOT_W-1:0]       slot = '0;
  logic [CC_W-1:0]         cc_number = '0;
  logic signed [CH_W-1:0]  channel = '0;
  logic [VAL_W-1:0]        cc_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [KIND_W-1:0]       kind;
  logic [SLOT_W-1:0]       target;
  logic [VAL_W-1:0]        level;
  logic signed [MCC_W-1:0] mapped_cc;
  logic                    last;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          counted_items = 0;

  mapping_scoreboard sb = new();

  midi_cc_learn_mapper #(
    .NUM_SLOTS(NSLOT),
    .NUM_STEMS(NSTEM)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .slot(slot),
    .cc_number(cc_number),
    .channel(channel),
    .cc_value(cc_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .target(target),
    .level(level),
    .mapped_cc(mapped_cc),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Output monitor: every result transfer goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{kind, target, level, mapped_cc, last});
    end
  end

  // Watchdog: a hung block or lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Drive one item: idle at random first, then hold valid and payload
  // until the transfer, then hand the item to the scoreboard.
  task automatic send(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] s,
                      input logic [CC_W-1:0] c, input logic signed [CH_W-1:0] h,
                      input logic [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    slot      <= s;
    cc_number <= c;
    channel   <= h;
    cc_value  <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, s, c, h, v);
    // Count only items that actually do something in the block.
    if (!(o > OP_QUERY ||
          ((o == OP_LEARN_ON || o == OP_SET || o == OP_REMOVE) && s >= NSLOT)))
      counted_items++;
  endtask

  // Mostly legal MIDI channels and "any", with some raw 6-bit codes mixed in.
  function automatic logic signed [CH_W-1:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CH_W'($urandom_range(1, 16));
    if (r < 80) return ANY_CH;
    return CH_W'($urandom);
  endfunction

  // Favor a small pool of controller numbers, edges included, so that
  // set, learn and message items keep colliding on the same numbers.
  function automatic logic [CC_W-1:0] pick_cc();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd63;
      3: return 7'd64;
      4: return 7'd126;
      5: return 7'd127;
      6: return 7'd42;
      default: return CC_W'($urandom);
    endcase
  endfunction

  // One random scenario: mostly messages that hit live mappings, plus
  // table edits, learn sequences and a share of noise.
  task automatic random_scenario();
    int pick;
    int j;
    logic [CC_W-1:0] c;
    logic signed [CH_W-1:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Aim at a mapped slot when there is one; else fall back to the pool.
      j = $urandom_range(0, NSLOT - 1);
      if (sb.slot_cc[j] != UNMAPPED_CC) begin
        c = sb.slot_cc[j][CC_W-1:0];
        h = (sb.slot_ch[j] == ANY_CH || $urandom_range(0, 4) == 0) ? pick_channel()
                                                                   : sb.slot_ch[j];
      end else begin
        c = pick_cc();
        h = pick_channel();
      end
      send(OP_MSG, SLOT_W'($urandom), c, h, VAL_W'($urandom));
    end else if (pick < 62) begin
      send(OP_SET, SLOT_W'($urandom_range(0, NSLOT - 1)), pick_cc(), pick_channel(),
           VAL_W'($urandom));
    end else if (pick < 72) begin
      send(OP_LEARN_ON, SLOT_W'($urandom_range(0, NSLOT - 1)), CC_W'($urandom),
           CH_W'($urandom), VAL_W'($urandom));
      if ($urandom_range(0, 4) == 0)
        send(OP_LEARN_OFF, SLOT_W'($urandom), CC_W'($urandom), CH_W'($urandom),
             VAL_W'($urandom));
      send(OP_MSG, SLOT_W'($urandom), pick_cc(), pick_channel(), VAL_W'($urandom));
    end else if (pick < 84) begin
      send(OP_QUERY, SLOT_W'($urandom), CC_W'($urandom), CH_W'($urandom),
           VAL_W'($urandom));
    end else if (pick < 90) begin
      send(OP_REMOVE, SLOT_W'($urandom_range(0, NSLOT - 1)), CC_W'($urandom),
           CH_W'($urandom), VAL_W'($urandom));
    end else begin
      // Noise: any op code, any field value.
      send(OP_W'($urandom), SLOT_W'($urandom), CC_W'($urandom), CH_W'($urandom),
           VAL_W'($urandom));
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int goal;
    idle_tab  = '{0, 85, 0, 17};
    stall_tab = '{0, 0, 85, 17};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling on either side.
    send(OP_QUERY, 4'd0, 7'd0, 6'sd0, 7'd0);           // fresh table reads unmapped
    send(OP_QUERY, 4'd15, 7'd127, -6'sd1, 7'd127);     // slot past the table
    send(OP_MSG, 4'd0, 7'd0, 6'sd1, 7'd0);             // nothing mapped, no result
    send(OP_SET, 4'd0, 7'd0, ANY_CH, 7'd0);
    send(OP_MSG, 4'd0, 7'd0, 6'sd16, 7'd0);            // any-channel slot, level 0
    send(OP_MSG, 4'd0, 7'd0, -6'sd32, 7'd127);         // odd channel code, level 127
    send(OP_SET, 4'd5, 7'd127, 6'sd31, 7'd0);
    send(OP_MSG, 4'd0, 7'd127, 6'sd31, 7'd85);         // channel stored as given
    send(OP_MSG, 4'd0, 7'd127, 6'sd30, 7'd85);         // wrong channel
    send(OP_SET, 4'd9, 7'd127, ANY_CH, 7'd0);          // steals 127 from slot 5
    send(OP_QUERY, 4'd5, 7'd0, 6'sd0, 7'd0);
    send(OP_MSG, 4'd0, 7'd127, 6'sd3, 7'd63);          // trigger just below threshold
    send(OP_MSG, 4'd0, 7'd127, 6'sd3, 7'd64);          // trigger at threshold
    send(OP_LEARN_ON, 4'd6, 7'd0, 6'sd0, 7'd0);
    send(OP_MSG, 4'd0, 7'd42, 6'sd7, 7'd10);           // captured, learned result
    send(OP_MSG, 4'd0, 7'd42, 6'sd7, 7'd127);          // now fires slot 6
    send(OP_LEARN_ON, 4'd3, 7'd0, 6'sd0, 7'd0);
    send(OP_LEARN_OFF, 4'd0, 7'd0, 6'sd0, 7'd0);       // disarm before any message
    send(OP_MSG, 4'd0, 7'd42, 6'sd7, 7'd100);
    send(OP_LEARN_ON, 4'd12, 7'd0, 6'sd0, 7'd0);       // out of range, dropped
    send(OP_MSG, 4'd0, 7'd0, 6'sd2, 7'd5);
    send(OP_SET, 4'd15, 7'd0, 6'sd4, 7'd0);            // out of range, dropped
    send(OP_REMOVE, 4'd0, 7'd0, 6'sd0, 7'd0);
    send(OP_REMOVE, 4'd14, 7'd0, 6'sd0, 7'd0);         // out of range, dropped
    send(OP_SPARE_A, 4'd0, 7'd0, 6'sd0, 7'd0);
    send(OP_SPARE_B, 4'd9, 7'd127, -6'sd1, 7'd127);

    // Random part in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      goal = counted_items + RANDOM_ITEMS / 4;
      while (counted_items < goal) random_scenario();
    end
    in_valid <= 1'b0;

    // Drain: every prediction must be matched, then stay quiet a while.
    stall_pct = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- midi_cc_learn_mapper.f -----
+incdir+rtl/core
rtl/core/mcl_pkg.sv
rtl/core/mcl_cell.sv
rtl/core/mcl_ctrl.sv
rtl/core/midi_cc_learn_mapper.sv
rtl/core/mcl_checker.sv
tb/tb.sv
